>>> design/ptu_pkg.sv
package ptu_pkg;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

  localparam int unsigned IDX_W   = $clog2(STORE_DEPTH);
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned CH_W    = $clog2(MAX_CHANNELS);
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned NCH_W   = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_DW  = 16;
  localparam int unsigned CFG_AW  = 2;

  typedef enum logic [MODE_W-1:0] {
    PRED_NONE  = 3'd0,
    PRED_LEFT  = 3'd1,
    PRED_UP    = 3'd2,
    PRED_AVG   = 3'd3,
    PRED_PAETH = 3'd4
  } pred_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WIDTH_W-1:0] width_pixels;
    logic [ROW_W-1:0]   height_rows;
    logic [NCH_W-1:0]   channel_count;
    logic [MODE_W-1:0]  predictor_mode;
  } cfg_t;

  // classified item, front to back
  typedef struct packed {
    logic [7:0]       resid;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  ch;
    logic             has_a;
    logic             has_b;
    logic             done;
    logic             err;
  } item_t;

endpackage

>>> design/ptu_front.sv
module ptu_front
  import ptu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] resid_i,
  input  logic       last_i,
  output item_t      item_o
);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CH_W-1:0]  chan_q, chan_d;

  logic [WIDTH_W-1:0] eff_w;
  logic [ROW_W-1:0]   eff_h;
  logic [NCH_W-1:0]   eff_n;
  logic chan_last, col_last, row_last, at_end, done;
  logic [COL_W+NCH_W-1:0] idx_full;

  always_comb begin
    if (cfg_i.width_pixels == '0) begin
      eff_w = WIDTH_W'(1);
    end else if (cfg_i.width_pixels > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = cfg_i.width_pixels;
    end
    eff_h = (cfg_i.height_rows == '0) ? ROW_W'(1) : cfg_i.height_rows;
    if (cfg_i.channel_count == '0) begin
      eff_n = NCH_W'(1);
    end else if (cfg_i.channel_count > NCH_W'(MAX_CHANNELS)) begin
      eff_n = NCH_W'(MAX_CHANNELS);
    end else begin
      eff_n = cfg_i.channel_count;
    end
  end

  assign chan_last = (NCH_W'(chan_q) + NCH_W'(1)) >= eff_n;
  assign col_last  = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= eff_w;
  assign row_last  = ({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
  assign at_end    = chan_last && col_last && row_last;
  assign done      = last_i || at_end;

  assign idx_full = (COL_W+NCH_W)'(col_q) * (COL_W+NCH_W)'(eff_n)
                  + (COL_W+NCH_W)'(chan_q);

  always_comb begin
    item_o.resid = resid_i;
    item_o.idx   = idx_full[IDX_W-1:0];
    item_o.ch    = chan_q;
    item_o.has_a = (col_q != '0);
    item_o.has_b = (row_q != '0);
    item_o.done  = done;
    item_o.err   = last_i ^ at_end;
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    chan_d = chan_q;
    if (accept_i) begin
      if (done) begin
        col_d  = '0;
        row_d  = '0;
        chan_d = '0;
      end else if (!chan_last) begin
        chan_d = chan_q + CH_W'(1);
      end else begin
        chan_d = '0;
        if (!col_last) begin
          col_d = col_q + COL_W'(1);
        end else begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      chan_q <= chan_d;
    end
  end

  // a tile end always rewinds the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && done |=> col_q == '0 && row_q == '0 && chan_q == '0)
    else $error("position not rewound after tile end");

endmodule

>>> design/ptu_queue.sv
module ptu_queue
  import ptu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("queue count out of range");

endmodule

>>> design/ptu_back.sv
module ptu_back
  import ptu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [MODE_W-1:0] mode_i,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_value_o,
  output logic        out_done_o,
  output logic        out_err_o
);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] left_q   [MAX_CHANNELS];
  logic [7:0] upleft_q [MAX_CHANNELS];

  item_t      e_q;
  logic       e_valid_q;
  logic       fwd_q;
  logic [7:0] fwd_val_q;

  logic       out_valid_q;
  logic [7:0] out_value_q;
  logic       out_done_q, out_err_q;

  logic       e_fire;
  logic [7:0] a, b, c, pred, val;
  logic [8:0] sum_ab;
  logic signed [9:0] p_a, p_b, p_c;

  function automatic logic signed [9:0] abs10(input logic signed [9:0] x);
    return x[9] ? -x : x;
  endfunction

  assign e_fire  = e_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!e_valid_q || e_fire);

  // up sample: bypass the write of the item leaving this stage
  assign b = !e_q.has_b ? 8'd0 : (fwd_q ? fwd_val_q : rd_q);
  assign a = e_q.has_a ? left_q[e_q.ch] : 8'd0;
  assign c = (e_q.has_a && e_q.has_b) ? upleft_q[e_q.ch] : 8'd0;

  assign sum_ab = {1'b0, a} + {1'b0, b};
  // distances to a+b-c
  assign p_a = abs10(10'(signed'({2'b00, b})) - 10'(signed'({2'b00, c})));
  assign p_b = abs10(10'(signed'({2'b00, a})) - 10'(signed'({2'b00, c})));
  assign p_c = abs10(10'(signed'({2'b00, a})) + 10'(signed'({2'b00, b}))
                     - 10'(signed'({1'b0, c, 1'b0})));

  always_comb begin
    case (pred_e'(mode_i))
      PRED_LEFT:  pred = a;
      PRED_UP:    pred = b;
      PRED_AVG:   pred = sum_ab[8:1];
      PRED_PAETH: begin
        if (p_a <= p_b && p_a <= p_c) begin
          pred = a;
        end else if (p_b <= p_c) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
  end

  assign val = pred + e_q.resid;

  // line store: read on entry to the compute stage, write on exit
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_q <= mem_q[q_item_i.idx];
    end
    if (e_fire) begin
      mem_q[e_q.idx] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      e_q       <= q_item_i;
      fwd_val_q <= val;
    end
    if (e_fire) begin
      out_value_q <= val;
      out_done_q  <= e_q.done;
      out_err_q   <= e_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i]   <= 8'd0;
        upleft_q[i] <= 8'd0;
      end
    end else begin
      if (q_pop_o) begin
        e_valid_q <= 1'b1;
        fwd_q     <= e_fire && (e_q.idx == q_item_i.idx);
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
        fwd_q     <= 1'b0;
      end
      if (e_fire) begin
        out_valid_q      <= 1'b1;
        left_q[e_q.ch]   <= val;
        upleft_q[e_q.ch] <= b;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_done_o  = out_done_q;
  assign out_err_o   = out_err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) fwd_q |-> e_valid_q)
    else $error("bypass flag without item in compute stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_done_q)
    else $error("format error without tile end");

  assert property (@(posedge clk_i) disable iff (!rst_ni) e_fire |=> out_valid_q)
    else $error("computed item did not reach output register");

endmodule

>>> design/predictive_tile_unfilter.sv
// Predictive tile unfilter: undoes per-sample prediction on an image tile.
// Input stream s_axis: one residual byte per item in raster order (rows, then
// pixels, then interleaved channels); tlast marks the final residual of a tile.
// Output stream m_axis: one reconstructed sample per input item, in order;
// tlast says the sample ends the tile, tuser flags a misplaced or missing last marker.
// Config port: cfg_we_i/cfg_idx_i/cfg_data_i, 0 width, 1 height, 2 channels,
// 3 predictor (0 none, 1 left, 2 up, 3 average, 4 paeth, others zero).
// Write config only with no item in flight.
// Throughput: one item per cycle while m_axis is ready. Path from input accept:
// queue, line store read into the compute stage, predict+add into the out reg.
// The left sample of a channel comes from a per-channel register updated by
// the previous result; the up sample from a 4096x8 line store with a bypass
// for a store write and read to the same entry in one cycle.
// Reset clears config to width 1, height 1, one channel, no prediction, and
// the position to tile start; the line store is not cleared.
// When m_axis stalls the output register holds, the back end stops, and the
// two-entry queue fills before s_axis_tready drops.
module predictive_tile_unfilter
  import ptu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] residual_byte
  input  logic              s_axis_tlast,   // residual_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] sample_value
  output logic              m_axis_tlast,   // tile_done
  output logic              m_axis_tuser,   // [0] format_error
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t front_item, q_item;
  logic  accept, q_ready, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_pixels   <= WIDTH_W'(1);
      cfg_q.height_rows    <= ROW_W'(1);
      cfg_q.channel_count  <= NCH_W'(1);
      cfg_q.predictor_mode <= MODE_W'(PRED_NONE);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_WIDTH:    cfg_q.width_pixels   <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT:   cfg_q.height_rows    <= cfg_data_i[ROW_W-1:0];
        CFG_CHANNELS: cfg_q.channel_count  <= cfg_data_i[NCH_W-1:0];
        CFG_MODE:     cfg_q.predictor_mode <= cfg_data_i[MODE_W-1:0];
        default:      ;
      endcase
    end
  end

  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;

  // position tracking and classification
  ptu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .resid_i  (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .item_o   (front_item)
  );

  ptu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // line store, prediction and output register
  ptu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (cfg_q.predictor_mode),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_done_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

>>> tb/sample_checker.sv
`timescale 1ns / 1ps

// Watches the residual, sample and config channels and keeps a model of the
// unfilter: predicts every sample at input accept, compares at output accept.
module sample_checker
  import ptu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [7:0]        m_axis_tdata,
  input  logic              m_axis_tlast,
  input  logic              m_axis_tuser,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  output int                mismatches_o,
  output int                outstanding_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       done;
    logic       err;
  } sample_t;

  sample_t expected_samples[$];

  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [NCH_W-1:0]   chans_q;
  logic [MODE_W-1:0]  mode_q;

  logic [7:0]  line_buf [STORE_DEPTH];
  logic [7:0]  left_q   [MAX_CHANNELS];
  logic [7:0]  upleft_q [MAX_CHANNELS];
  int unsigned col_q, row_q, chan_q;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) line_buf[i] = 8'h00;
  end

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, b, c);
    int ia, ib, ic, p, da, db, dc;
    ia = int'(a);
    ib = int'(b);
    ic = int'(c);
    p  = ia + ib - ic;
    da = (p > ia) ? p - ia : ia - p;
    db = (p > ib) ? p - ib : ib - p;
    dc = (p > ic) ? p - ic : ic - p;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic logic [7:0] predict(input logic [7:0] a, b, c);
    case (mode_q)
      PRED_LEFT:  return a;
      PRED_UP:    return b;
      PRED_AVG:   return 8'((9'(a) + 9'(b)) >> 1);
      PRED_PAETH: return paeth_pick(a, b, c);
      default:    return 8'h00;
    endcase
  endfunction

  // one residual in, one sample out; advances the raster position
  function automatic sample_t reconstruct(input logic [7:0] resid, input logic last);
    int unsigned w, h, nch, ch, idx;
    logic [7:0]  a, b, c;
    logic        at_end;
    sample_t     s;
    w   = (width_q == 0) ? 1 : (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
    h   = (height_q == 0) ? 1 : height_q;
    nch = (chans_q == 0) ? 1 : (chans_q > MAX_CHANNELS) ? MAX_CHANNELS : chans_q;
    ch  = chan_q % MAX_CHANNELS;
    idx = col_q * nch + ch;
    a = (col_q > 0) ? left_q[CH_W'(ch)] : 8'h00;
    b = (row_q > 0 && idx < STORE_DEPTH) ? line_buf[IDX_W'(idx)] : 8'h00;
    c = (col_q > 0 && row_q > 0) ? upleft_q[CH_W'(ch)] : 8'h00;
    s.value = predict(a, b, c) + resid;
    if (idx < STORE_DEPTH) line_buf[IDX_W'(idx)] = s.value;
    left_q[CH_W'(ch)]   = s.value;
    upleft_q[CH_W'(ch)] = b;
    at_end = (chan_q + 1 >= nch) && (col_q + 1 >= w) && (row_q + 1 >= h);
    s.done = last || at_end;
    s.err  = last != at_end;
    if (s.done) begin
      chan_q = 0;
      col_q  = 0;
      row_q  = 0;
    end else if (chan_q + 1 < nch) begin
      chan_q++;
    end else begin
      chan_q = 0;
      if (col_q + 1 < w) begin
        col_q++;
      end else begin
        col_q = 0;
        row_q = (row_q + 1) & 32'hFFFF;
      end
    end
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got, want;
    if (!rst_ni) begin
      width_q  = WIDTH_W'(1);
      height_q = ROW_W'(1);
      chans_q  = NCH_W'(1);
      mode_q   = PRED_NONE;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_q[i]   = 8'h00;
        upleft_q[i] = 8'h00;
      end
      col_q  = 0;
      row_q  = 0;
      chan_q = 0;
      expected_samples.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample: expected none, actual %h done %b err %b",
                   $time, got.value, got.done, got.err);
          mismatches_o++;
        end else begin
          want = expected_samples.pop_front();
          if (got.value !== want.value || got.done !== want.done || got.err !== want.err) begin
            $display("%0t: mismatch: expected %h done %b err %b, actual %h done %b err %b",
                     $time, want.value, want.done, want.err, got.value, got.done, got.err);
            mismatches_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(reconstruct(s_axis_tdata, s_axis_tlast));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:    width_q  = cfg_data_i[WIDTH_W-1:0];
          CFG_HEIGHT:   height_q = cfg_data_i[ROW_W-1:0];
          CFG_CHANNELS: chans_q  = cfg_data_i[NCH_W-1:0];
          CFG_MODE:     mode_q   = cfg_data_i[MODE_W-1:0];
          default: ;
        endcase
      end
      outstanding_o = expected_samples.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the tile unfilter. The checker next to the DUT
// does all prediction and comparison; this module only feeds items, drives
// the sink ready, writes config between phases and decides pass/fail.
module testbench;
  import ptu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no accept or config write at all
  localparam int unsigned HOLD_CYCLES  = 80;    // long sink hold-off
  localparam int unsigned DRAIN_CYCLES = 10;    // settle time after the final drain
  localparam int unsigned TILE_CAP     = 200;   // random tiles longer than this end early

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i     = CFG_WIDTH;
  logic [CFG_DW-1:0] cfg_data_i    = '0;

  int mismatches, outstanding;

  bit quiet    = 1'b0;  // no random idling on either side while set
  bit hold_req = 1'b0;  // asks the sink for one long hold-off

  predictive_tile_unfilter u_top (.*);

  sample_checker u_checker (
    .*,
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // sink: random backpressure, one long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  // watchdog: ends the run if nothing moves for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[predictive_tile_unfilter] ERROR");
        $finish;
      end
    end
  end

  // Offer one residual item; random gaps before it unless quiet.
  // Called at a falling edge, returns at the falling edge after the accept.
  task automatic send_residual(input logic [7:0] resid, input logic last);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= resid;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Sender pauses until every predicted sample has come out.
  // Always waits for a falling edge first so valid is not dropped and raised in one step.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // All four registers; unused upper data bits get junk, the block ignores them.
  task automatic apply_config(input int unsigned w, h, c, m);
    write_reg(CFG_WIDTH,    {5'($urandom),  WIDTH_W'(w)});
    write_reg(CFG_HEIGHT,   CFG_DW'(h));
    write_reg(CFG_CHANNELS, {13'($urandom), NCH_W'(c)});
    write_reg(CFG_MODE,     {13'($urandom), MODE_W'(m)});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_residual();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0]  pattern [4];
    int unsigned phase, random_items, tiles, total, stop, w, h, c, m, r;
    int unsigned ew, eh, ec;
    bit          big_done, last_flag;

    pattern      = '{8'hFF, 8'h01, 8'h80, 8'h7F};
    random_items = 0;
    big_done     = 1'b0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // reset config is a 1x1x1 tile: a proper last, then a missing last
    send_residual(8'h00, 1'b1);
    send_residual(8'hFF, 1'b0);

    // every real predictor on a 2x2 single-channel tile, so up/up-left are used
    for (int pm = PRED_LEFT; pm <= PRED_PAETH; pm++) begin
      wait_drained();
      apply_config(2, 2, 1, pm);
      for (int i = 0; i < 4; i++) send_residual(pattern[i], i == 3);
    end
    // early last right at the start of a tile
    send_residual(8'h55, 1'b1);

    // zero width/height/channels clamp up to 1
    wait_drained();
    apply_config(0, 0, 0, PRED_UP);
    send_residual(8'h80, 1'b1);
    send_residual(8'h7F, 1'b0);

    // ---- random phases ----
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      wait_drained();

      if (!big_done && random_items >= RANDOM_ITEMS / 4) begin
        // Full-width tile: a whole row of MAX_WIDTH samples, then into the
        // next row so up samples come from the line store. The sink holds
        // off at the start while we keep offering, so the input queue fills.
        big_done = 1'b1;
        quiet    = 1'b1;
        apply_config(MAX_WIDTH, 3, 1, PRED_PAETH);
        hold_req = 1'b1;
        stop = MAX_WIDTH + $urandom_range(0, 199);
        for (int unsigned i = 0; i <= stop; i++) send_residual(pick_residual(), i == stop);
        random_items += stop + 1;
        wait_drained();
      end

      // a stretch of phases with no idling at all
      quiet = (phase >= 3 && phase < 6);

      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 3))
          0:       w = 0;
          1:       w = MAX_WIDTH;
          2:       w = MAX_WIDTH + 1;
          default: w = 2047;
        endcase
      end else begin
        w = $urandom_range(1, 8);
      end
      r = $urandom_range(0, 99);
      if (r < 5) h = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      else       h = $urandom_range(1, 4);
      c = $urandom_range(0, 7);
      m = $urandom_range(0, 7);
      apply_config(w, h, c, m);

      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : h;
      ec = (c == 0) ? 1 : (c > MAX_CHANNELS) ? MAX_CHANNELS : c;
      total = ew * eh * ec;

      tiles = $urandom_range(1, 4);
      for (int unsigned t = 0; t < tiles; t++) begin
        r = $urandom_range(0, 99);
        if (total > TILE_CAP || (r < 12 && total > 1)) begin
          // early last somewhere in the tile
          stop = $urandom_range(0, ((total > TILE_CAP) ? TILE_CAP : total) - 1);
          last_flag = 1'b1;
        end else begin
          // full tile: mostly a proper last, sometimes the last is missing
          stop = total - 1;
          last_flag = (r < 92);
        end
        for (int unsigned i = 0; i <= stop; i++)
          send_residual(pick_residual(), (i == stop) && last_flag);
        random_items += stop + 1;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[predictive_tile_unfilter] OK");
    end else begin
      $display("[predictive_tile_unfilter] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ptu_pkg.sv
design/ptu_front.sv
design/ptu_queue.sv
design/ptu_back.sv
design/predictive_tile_unfilter.sv
tb/sample_checker.sv
tb/testbench.sv
